// ----- design/dcd_pkg.sv -----
// dcd_pkg: shared types and constants for the directed cycle detector
// words on both channels, sequencer states, register index and default sizes
// no dependencies
package dcd_pkg;

  localparam int DCD_MAX_NODES = 1024;
  localparam int DCD_MAX_EDGES = 4096;

  localparam logic [10:0] NODE_COUNT_RESET = 11'd1024;
  localparam logic        REG_NODE_COUNT   = 1'b0;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [9:0] src_node;
    logic [9:0] dst_node;
  } in_word_t;

  typedef struct packed {
    logic       cycle_found;
    logic [9:0] root_node;
    logic       edge_overflow;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_STEP,
    ST_EDGE_WAIT,
    ST_TGT_WAIT,
    ST_POP_WAIT,
    ST_DONE
  } dcd_state_t;

endpackage

// ----- design/directed_cycle_detector_core.sv -----
// Directed cycle detector: edges arrive one word each on the input channel; an
// evaluate word runs a depth-first search over the loaded graph and returns one result
// word. Depends on dcd_pkg, dcd_ram and dcd_ctrl.
//
// An edge word is a read of the source's list head, then the write of the edge and
// the new head. An evaluate word reads and checks each root node scanned, follows
// each edge through a step, an edge read and a target read, pops each node through a
// step and a stack read, and then runs a clearing pass over the node store before
// the next word is accepted; the steps follow the registered reads of the node, edge
// and stack rams, which the sequencer visits one access at a time. The same clearing
// pass runs after reset. Edges with an endpoint outside node_count are dropped
// silently; edges beyond MAX_EDGES are dropped and flagged in the result.
module directed_cycle_detector_core #(
  parameter int MAX_NODES = dcd_pkg::DCD_MAX_NODES,
  parameter int MAX_EDGES = dcd_pkg::DCD_MAX_EDGES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dcd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dcd_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dcd_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int LW = $clog2(MAX_EDGES + 1);
  localparam int EW = $clog2(MAX_EDGES);

  logic [10:0]        node_count_r;
  logic [NW-1:0]      node_raddr;
  logic [LW-1:0]      head_rdata;
  logic [1:0]         mark_rdata;
  logic               head_we;
  logic [NW-1:0]      head_waddr;
  logic [LW-1:0]      head_wdata;
  logic               mark_we;
  logic [NW-1:0]      mark_waddr;
  logic [1:0]         mark_wdata;
  logic [EW-1:0]      edge_raddr;
  logic [LW+9:0]      edge_rdata;
  logic               edge_we;
  logic [EW-1:0]      edge_waddr;
  logic [LW+9:0]      edge_wdata;
  logic [NW-1:0]      stk_raddr;
  logic [NW+LW-1:0]   stk_rdata;
  logic               stk_we;
  logic [NW-1:0]      stk_waddr;
  logic [NW+LW-1:0]   stk_wdata;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? {21'd0, node_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NODE_COUNT) begin
      node_count_r <= pwdata[10:0];
    end
  end

  // sequencer
  dcd_ctrl #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .NW        (NW),
    .LW        (LW),
    .EW        (EW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .node_count (node_count_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .node_raddr (node_raddr),
    .head_rdata (head_rdata),
    .mark_rdata (mark_rdata),
    .head_we    (head_we),
    .head_waddr (head_waddr),
    .head_wdata (head_wdata),
    .mark_we    (mark_we),
    .mark_waddr (mark_waddr),
    .mark_wdata (mark_wdata),
    .edge_raddr (edge_raddr),
    .edge_rdata (edge_rdata),
    .edge_we    (edge_we),
    .edge_waddr (edge_waddr),
    .edge_wdata (edge_wdata),
    .stk_raddr  (stk_raddr),
    .stk_rdata  (stk_rdata),
    .stk_we     (stk_we),
    .stk_waddr  (stk_waddr),
    .stk_wdata  (stk_wdata)
  );

  // adjacency list heads
  dcd_ram #(.DEPTH(MAX_NODES), .WIDTH(LW)) u_head_ram (
    .clk (clk), .we (head_we), .waddr (head_waddr), .wdata (head_wdata),
    .raddr (node_raddr), .rdata (head_rdata)
  );

  // seen and on-path marks
  dcd_ram #(.DEPTH(MAX_NODES), .WIDTH(2)) u_mark_ram (
    .clk (clk), .we (mark_we), .waddr (mark_waddr), .wdata (mark_wdata),
    .raddr (node_raddr), .rdata (mark_rdata)
  );

  // edge links and targets
  dcd_ram #(.DEPTH(MAX_EDGES), .WIDTH(LW + 10)) u_edge_ram (
    .clk (clk), .we (edge_we), .waddr (edge_waddr), .wdata (edge_wdata),
    .raddr (edge_raddr), .rdata (edge_rdata)
  );

  // search stack
  dcd_ram #(.DEPTH(MAX_NODES), .WIDTH(NW + LW)) u_stack_ram (
    .clk (clk), .we (stk_we), .waddr (stk_waddr), .wdata (stk_wdata),
    .raddr (stk_raddr), .rdata (stk_rdata)
  );

endmodule

// ----- design/dcd_ram.sv -----
// dcd_ram: simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module dcd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/dcd_ctrl.sv -----
// dcd_ctrl: sequencer for edge loading, depth-first search and store clearing
// depends on dcd_pkg; drives the node, mark, edge and stack rams in the top level
module dcd_ctrl #(
  parameter int MAX_NODES = dcd_pkg::DCD_MAX_NODES,
  parameter int MAX_EDGES = dcd_pkg::DCD_MAX_EDGES,
  parameter int NW = $clog2(MAX_NODES),
  parameter int LW = $clog2(MAX_EDGES + 1),
  parameter int EW = $clog2(MAX_EDGES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [10:0]        node_count,
  input  logic               in_valid,
  output logic               in_ready,
  input  dcd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dcd_pkg::out_word_t out_data,
  // node rams: list head and {seen, on_path}
  output logic [NW-1:0]      node_raddr,
  input  logic [LW-1:0]      head_rdata,
  input  logic [1:0]         mark_rdata,
  output logic               head_we,
  output logic [NW-1:0]      head_waddr,
  output logic [LW-1:0]      head_wdata,
  output logic               mark_we,
  output logic [NW-1:0]      mark_waddr,
  output logic [1:0]         mark_wdata,
  // edge ram: {next link, target}
  output logic [EW-1:0]      edge_raddr,
  input  logic [LW+9:0]      edge_rdata,
  output logic               edge_we,
  output logic [EW-1:0]      edge_waddr,
  output logic [LW+9:0]      edge_wdata,
  // stack ram: {node, link} of entries below the top
  output logic [NW-1:0]      stk_raddr,
  input  logic [NW+LW-1:0]   stk_rdata,
  output logic               stk_we,
  output logic [NW-1:0]      stk_waddr,
  output logic [NW+LW-1:0]   stk_wdata
);
  import dcd_pkg::*;

  dcd_state_t       state_r, state_nxt;
  logic [10:0]      r_r, r_nxt;
  logic [NW-1:0]    top_node_r, top_node_nxt;
  logic [LW-1:0]    top_link_r, top_link_nxt;
  logic [NW:0]      depth_r, depth_nxt;
  logic [LW-1:0]    edge_total_r, edge_total_nxt;
  logic             overflow_r, overflow_nxt;
  logic             found_r, found_nxt;
  logic [NW:0]      clr_r, clr_nxt;
  logic [NW-1:0]    tgt_r, tgt_nxt;
  logic [9:0]       src_r, src_nxt;
  logic [9:0]       dst_r, dst_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic [10:0]      eff_count;
  logic             edge_in_range;
  logic             store_full;
  logic             scan_last;
  logic             out_free;
  logic [LW-1:0]    e_next;
  logic [9:0]       e_tgt;
  logic             e_tgt_ok;

  // effective node count and small decodes
  assign eff_count = (MAX_NODES >= 2048 || node_count <= 11'(MAX_NODES)) ?
                     node_count : 11'(MAX_NODES);
  assign edge_in_range = ({1'b0, in_data.src_node} < eff_count) &&
                         ({1'b0, in_data.dst_node} < eff_count);
  assign store_full = (edge_total_r == LW'(MAX_EDGES));
  assign scan_last  = ({1'b0, r_r} + 12'd1) >= {1'b0, eff_count};
  assign out_free   = !out_valid_r || out_ready;
  assign e_next     = edge_rdata[LW+9:10];
  assign e_tgt      = edge_rdata[9:0];
  assign e_tgt_ok   = {1'b0, e_tgt} < eff_count;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == (NW+1)'(MAX_NODES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == KIND_EVAL) begin
            state_nxt = (eff_count == 11'd0) ? ST_DONE : ST_SCAN_RD;
          end else if (edge_in_range && !store_full) begin
            state_nxt = ST_EDGE_WR;
          end
        end
      end
      ST_EDGE_WR:  state_nxt = ST_IDLE;
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!mark_rdata[1] && head_rdata != '0) state_nxt = ST_STEP;
        else if (scan_last)                     state_nxt = ST_DONE;
        else                                    state_nxt = ST_SCAN_RD;
      end
      ST_STEP: begin
        if (top_link_r != '0)          state_nxt = ST_EDGE_WAIT;
        else if (depth_r != (NW+1)'(1)) state_nxt = ST_POP_WAIT;
        else if (scan_last)            state_nxt = ST_DONE;
        else                           state_nxt = ST_SCAN_RD;
      end
      ST_EDGE_WAIT: state_nxt = e_tgt_ok ? ST_TGT_WAIT : ST_STEP;
      ST_TGT_WAIT: begin
        if (!mark_rdata[1] || !mark_rdata[0]) state_nxt = ST_STEP;
        else                                  state_nxt = ST_DONE;
      end
      ST_POP_WAIT: state_nxt = ST_STEP;
      ST_DONE: begin
        if (out_free) state_nxt = ST_CLEAR;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // memory strobes and datapath
  always_comb begin
    r_nxt          = r_r;
    top_node_nxt   = top_node_r;
    top_link_nxt   = top_link_r;
    depth_nxt      = depth_r;
    edge_total_nxt = edge_total_r;
    overflow_nxt   = overflow_r;
    found_nxt      = found_r;
    clr_nxt        = clr_r;
    tgt_nxt        = tgt_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    node_raddr     = NW'(r_r);
    head_we        = 1'b0;
    head_waddr     = NW'(src_r);
    head_wdata     = edge_total_r + LW'(1);
    mark_we        = 1'b0;
    mark_waddr     = top_node_r;
    mark_wdata     = 2'b10;
    edge_raddr     = EW'(top_link_r - LW'(1));
    edge_we        = 1'b0;
    edge_waddr     = EW'(edge_total_r);
    edge_wdata     = {head_rdata, dst_r};
    stk_raddr      = NW'(depth_r - (NW+1)'(2));
    stk_we         = 1'b0;
    stk_waddr      = NW'(depth_r - (NW+1)'(1));
    stk_wdata      = {top_node_r, top_link_r};
    case (state_r)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r[NW-1:0];
        head_wdata = '0;
        mark_we    = 1'b1;
        mark_waddr = clr_r[NW-1:0];
        mark_wdata = 2'b00;
        clr_nxt    = clr_r + (NW+1)'(1);
      end
      ST_IDLE: begin
        node_raddr = NW'(in_data.src_node);
        src_nxt    = in_data.src_node;
        dst_nxt    = in_data.dst_node;
        r_nxt      = '0;
        found_nxt  = 1'b0;
        if (in_valid && in_data.kind == KIND_EDGE && edge_in_range && store_full) begin
          overflow_nxt = 1'b1;
        end
      end
      ST_EDGE_WR: begin
        edge_we        = 1'b1;
        head_we        = 1'b1;
        edge_total_nxt = edge_total_r + LW'(1);
      end
      ST_SCAN_CHK: begin
        if (!mark_rdata[1] && head_rdata != '0) begin
          mark_we      = 1'b1;
          mark_waddr   = NW'(r_r);
          mark_wdata   = 2'b11;
          top_node_nxt = NW'(r_r);
          top_link_nxt = head_rdata;
          depth_nxt    = (NW+1)'(1);
        end else if (!scan_last) begin
          r_nxt = r_r + 11'd1;
        end
      end
      ST_STEP: begin
        if (top_link_r == '0) begin
          // pop: node leaves the current path
          mark_we   = 1'b1;
          depth_nxt = depth_r - (NW+1)'(1);
          if (depth_r == (NW+1)'(1) && !scan_last) r_nxt = r_r + 11'd1;
        end
      end
      ST_EDGE_WAIT: begin
        top_link_nxt = e_next;
        tgt_nxt      = NW'(e_tgt);
        node_raddr   = NW'(e_tgt);
      end
      ST_TGT_WAIT: begin
        if (!mark_rdata[1]) begin
          // push: park the current top, descend into the target
          stk_we       = 1'b1;
          mark_we      = 1'b1;
          mark_waddr   = tgt_r;
          mark_wdata   = 2'b11;
          top_node_nxt = tgt_r;
          top_link_nxt = head_rdata;
          depth_nxt    = depth_r + (NW+1)'(1);
        end else if (mark_rdata[0]) begin
          found_nxt = 1'b1;
        end
      end
      ST_POP_WAIT: begin
        top_node_nxt = stk_rdata[NW+LW-1:LW];
        top_link_nxt = stk_rdata[LW-1:0];
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.cycle_found   = found_r;
          out_data_nxt.root_node     = found_r ? r_r[9:0] : 10'd0;
          out_data_nxt.edge_overflow = overflow_r;
          clr_nxt        = '0;
          edge_total_nxt = '0;
          overflow_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      depth_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      edge_total_r <= edge_total_nxt;
      overflow_r   <= overflow_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
      depth_r      <= depth_nxt;
    end
    r_r        <= r_nxt;
    top_node_r <= top_node_nxt;
    top_link_r <= top_link_nxt;
    tgt_r      <= tgt_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    out_data_r <= out_data_nxt;
  end

  // stack never grows past the node store size MAX_NODES
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= (NW+1)'(MAX_NODES))
    else $error("search stack deeper than node store");

  // edge count stays within the store
  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= LW'(MAX_EDGES))
    else $error("edge count beyond store size");

  // the clearing pass always starts from an empty edge store
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> edge_total_r == '0 && !overflow_r)
    else $error("edge store not reset during clearing pass");

  // a result is loaded only on leaving the done state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result word raised outside done state");

endmodule

// ----- tb/directed_cycle_detector_core_tb.sv -----
// directed_cycle_detector_core_tb: self-checking bench for the directed cycle detector
// loads edge words, evaluates, and compares each result word against a dfs predictor
// depends on dcd_pkg and directed_cycle_detector_core
module directed_cycle_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dcd_pkg::*;

  localparam int NODES = DCD_MAX_NODES;
  localparam int EDGES = DCD_MAX_EDGES;
  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #4 clk = ~clk;

  directed_cycle_detector_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // graph model state
  logic [10:0] node_limit;
  int head_link[NODES];
  int next_link[EDGES];
  int edge_dst[EDGES];
  int edge_cnt;
  bit dropped;
  bit visited[NODES];
  bit on_path[NODES];
  int path_node[NODES];
  int path_link[NODES];

  out_word_t result_q[$];
  int mismatches = 0;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  function automatic void graph_clear();
    for (int i = 0; i < NODES; i++) begin
      head_link[i] = 0; visited[i] = 0; on_path[i] = 0;
    end
    edge_cnt = 0;
    dropped = 0;
  endfunction

  function automatic int active_count();
    return (node_limit > NODES) ? NODES : int'(node_limit);
  endfunction

  // depth-first search from one root, true on a back edge
  function automatic bit dfs_hits_cycle(int root, int cnt);
    int depth, top, nd, lk, tgt;
    depth = 1;
    path_node[0] = root; path_link[0] = head_link[root];
    visited[root] = 1; on_path[root] = 1;
    while (depth > 0) begin
      top = depth - 1;
      nd = path_node[top];
      lk = path_link[top];
      if (lk == 0 || lk > EDGES) begin
        on_path[nd] = 0;
        depth--;
      end else begin
        path_link[top] = next_link[lk-1];
        tgt = edge_dst[lk-1];
        if (tgt < cnt) begin
          if (!visited[tgt]) begin
            if (depth < NODES) begin
              visited[tgt] = 1; on_path[tgt] = 1;
              path_node[depth] = tgt; path_link[depth] = head_link[tgt];
              depth++;
            end
          end else if (on_path[tgt]) begin
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // apply one accepted input word to the model
  function automatic void graph_apply(in_word_t w);
    int cnt;
    out_word_t r;
    cnt = active_count();
    if (w.kind == KIND_EDGE) begin
      if (w.src_node < cnt && w.dst_node < cnt) begin
        if (edge_cnt >= EDGES) dropped = 1;
        else begin
          edge_dst[edge_cnt] = w.dst_node;
          next_link[edge_cnt] = head_link[w.src_node];
          head_link[w.src_node] = edge_cnt + 1;
          edge_cnt++;
        end
      end
    end else begin
      r = '0;
      for (int n = 0; n < cnt; n++) begin
        if (!visited[n] && head_link[n] != 0 && dfs_hits_cycle(n, cnt)) begin
          r.cycle_found = 1'b1;
          r.root_node = n[9:0];
          break;
        end
      end
      r.edge_overflow = dropped;
      result_q = {result_q, r};
      graph_clear();
    end
  endfunction

  // send one word, random gaps unless quiet
  task automatic send_word(input in_word_t w);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    graph_apply(w);
  endtask

  task automatic send_edge(input int s, input int d);
    in_word_t w;
    w.kind = KIND_EDGE; w.src_node = s[9:0]; w.dst_node = d[9:0];
    send_word(w);
  endtask

  task automatic send_eval();
    in_word_t w;
    w.kind = KIND_EVAL; w.src_node = 10'($urandom); w.dst_node = 10'($urandom);
    send_word(w);
  endtask

  // wait for all results, then for the clearing pass
  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (NODES + 64) @(posedge clk);
  endtask

  task automatic write_node_limit(input logic [10:0] v);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * REG_NODE_COUNT); pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    node_limit = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n) out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_data);
      end else begin
        automatic out_word_t exp_w = result_q.pop_front();
        if (out_data.cycle_found !== exp_w.cycle_found
            || out_data.root_node !== exp_w.root_node
            || out_data.edge_overflow !== exp_w.edge_overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", exp_w, out_data);
        end
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_eval();                      // empty graph
    send_edge(5, 5); send_eval();     // self loop
    send_edge(0, 1); send_edge(1, 2); send_edge(2, 0); send_eval();
    send_edge(0, 1); send_edge(1, 2); send_edge(0, 2); send_eval(); // dag
    send_edge(1023, 0); send_edge(0, 1023); send_eval();
    send_edge(3, 4); send_edge(7, 8); send_edge(8, 7); send_eval();
  endtask

  task automatic test_range();
    write_node_limit(11'd4);
    send_edge(0, 9); send_edge(9, 0); send_edge(1, 1023); send_edge(3, 2);
    send_edge(2, 3); send_eval();
    write_node_limit(11'd1);
    send_edge(0, 0); send_edge(0, 1); send_eval();
    write_node_limit(11'd0);
    send_edge(0, 0); send_eval();
    write_node_limit(11'd2047);
    send_edge(1023, 1023); send_eval();
    write_node_limit(11'd1024);
  endtask

  task automatic test_overflow();
    quiet = 1'b1;
    for (int i = 0; i < EDGES + 5; i++) send_edge(i % 1024, (i * 7 + 1) % 1024);
    quiet = 1'b0;
    send_eval();
  endtask

  task automatic test_random();
    int sz, ne;
    for (int k = 0; k < 50; k++) begin
      if (k % 12 == 0) write_node_limit($urandom_range(3) == 0 ? 11'd1024 :
                                        11'($urandom_range(1, 40)));
      quiet = (k >= 20 && k < 28);
      sz = active_count();
      ne = $urandom_range(1, 40);
      for (int e = 0; e < ne; e++) begin
        if ($urandom_range(9) == 0) send_edge($urandom_range(1023), $urandom_range(1023));
        else if (sz > 0) send_edge($urandom_range(sz - 1), $urandom_range(sz - 1));
        else send_edge($urandom_range(1023), $urandom_range(1023));
      end
      send_eval();
    end
    quiet = 1'b0;
  endtask

  initial begin
    node_limit = NODE_COUNT_RESET;
    graph_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_range();
    test_overflow();
    test_random();
    drain();
    if (mismatches == 0 && result_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
